// ===== hw/rtl/lpt_pkg.sv =====
package lpt_pkg;

  localparam int unsigned VIRT_PAGES_DEF      = 256;
  localparam int unsigned FRAMES_DEF          = 8;
  localparam int unsigned MAX_OFFSET_BITS_DEF = 8;

  localparam int unsigned VA_W    = 16;
  localparam int unsigned PHYS_W  = 11;
  localparam int unsigned FUSED_W = 3;
  localparam int unsigned FCNT_W  = 16;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned OUT_W   = 32;

  localparam logic [CIDX_W-1:0] CFG_IDX_OFFSET_BITS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IDX_FRAMES      = 2'd1;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd7;
  localparam logic [CFG_W-1:0] FRAMES_RST      = 4'd8;
  localparam logic [CFG_W-1:0] OFFSET_BITS_MIN = 4'd4;

  typedef struct packed {
    logic idx_clr;
    logic idx_load;
    logic idx_inc;
    logic carry_ld;
    logic rot_step;
  } rec_op_t;

endpackage

// ===== hw/rtl/lpt_map_ram.sv =====
module lpt_map_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lpt_recency.sv =====
module lpt_recency import lpt_pkg::*; #(
  parameter int unsigned FRAMES = 8,
  parameter int unsigned PAGE_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rec_op_t                     op_i,
  input  logic [$clog2(FRAMES+1)-1:0] load_idx_i,
  input  logic [PAGE_W-1:0]           key_i,
  output logic [$clog2(FRAMES+1)-1:0] idx_o,
  output logic [PAGE_W-1:0]           entry_o,
  output logic                        match_o
);

  localparam int unsigned FW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(FRAMES + 1);

  logic [PAGE_W-1:0] rec_q [FRAMES];
  logic [PAGE_W-1:0] carry_q;
  logic [CW-1:0]     idx_q, idx_d;

  // The list is rotated by one slot from the head down to the target slot,
  // so each rotation step reads and writes the single slot under the index.
  assign entry_o = rec_q[idx_q[FW-1:0]];
  assign match_o = (entry_o == key_i);
  assign idx_o   = idx_q;

  always_comb begin
    idx_d = idx_q;
    if (op_i.idx_clr) begin
      idx_d = '0;
    end else if (op_i.idx_load) begin
      idx_d = load_idx_i;
    end else if (op_i.idx_inc || op_i.rot_step) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.carry_ld) begin
      carry_q <= key_i;
    end else if (op_i.rot_step) begin
      carry_q <= entry_o;
    end
    if (op_i.rot_step) begin
      rec_q[idx_q[FW-1:0]] <= carry_q;
    end
  end

endmodule

// ===== hw/rtl/lru_page_translation.sv =====
// Translates 16-bit virtual addresses through a page map with least recently
// used replacement over a configurable number of frames. After reset the
// block clears every page map entry and accepts no address meanwhile;
// configuration writes are taken at any time but only while idle are they
// safe. An out-of-range page skips the page map and goes straight to its
// result. A hit reads the page map, searches the recency list for the page
// and rotates the list from the head down to the page's slot. A fault rotates
// the list down to its last occupied slot, and a fault that evicts a page
// first reads the victim's map entry. Translation time is set by the
// recency list, which is searched and rotated one slot a cycle through a
// single port, and by the one-port page map memory. A finished result waits
// for the output register to drain before the next address is taken, and
// then waits in that output register while the next address is taken.
module lru_page_translation import lpt_pkg::*; #(
  parameter int unsigned VIRT_PAGES      = VIRT_PAGES_DEF,
  parameter int unsigned FRAMES          = FRAMES_DEF,
  parameter int unsigned MAX_OFFSET_BITS = MAX_OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // virt_addr[15:0]
  input  logic [VA_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // phys_addr[10:0], frame_used[13:11], page_fault[14], out_of_range[15],
  // fault_total[31:16]
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(VIRT_PAGES);
  localparam int unsigned FW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned EW = FW + 1;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b00000001,
    ST_IDLE   = 8'b00000010,
    ST_LOOK   = 8'b00000100,
    ST_SEARCH = 8'b00001000,
    ST_VSEL   = 8'b00010000,
    ST_VREAD  = 8'b00100000,
    ST_SHIFT  = 8'b01000000,
    ST_DONE   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  ob_cfg_q, fr_cfg_q;
  logic [CW-1:0]     rc_q, rc_d;
  logic [FCNT_W-1:0] fault_cnt_q, fault_cnt_d;
  logic [AW-1:0]     clr_cnt_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  logic [AW-1:0]              pg_q, victim_q;
  logic [MAX_OFFSET_BITS-1:0] off_q;
  logic [CFG_W-1:0]           ob_q;
  logic                       oor_q, fault_q;
  logic [FW-1:0]              frame_q;
  logic [CW-1:0]              pos_q;

  logic [CFG_W-1:0] ob_w;
  logic [CW-1:0]    limit_w;
  logic [VA_W-1:0]  pg_full, off_full;
  logic             oor_w;
  logic             in_acc, out_free;

  logic          map_we;
  logic [AW-1:0] map_addr;
  logic [EW-1:0] map_wdata, map_rdata;
  logic          map_hit;

  rec_op_t       rec_op;
  logic [CW-1:0] rec_load_idx, rec_idx;
  logic [AW-1:0] rec_entry;
  logic          rec_match;

  logic             search_end, search_hit;
  logic [CW-1:0]    search_pos;
  logic [VA_W-1:0]  phys_full;
  logic [31:0]      frame_ext;
  logic [OUT_W-1:0] result_w;

  // Configuration clamps.
  always_comb begin
    if (ob_cfg_q < OFFSET_BITS_MIN) begin
      ob_w = OFFSET_BITS_MIN;
    end else if (32'(ob_cfg_q) > MAX_OFFSET_BITS) begin
      ob_w = CFG_W'(MAX_OFFSET_BITS);
    end else begin
      ob_w = ob_cfg_q;
    end
    if (fr_cfg_q == '0) begin
      limit_w = CW'(1);
    end else if (32'(fr_cfg_q) >= FRAMES) begin
      limit_w = CW'(FRAMES);
    end else begin
      limit_w = CW'(fr_cfg_q);
    end
  end

  assign pg_full  = s_axis_tdata >> ob_w;
  assign off_full = s_axis_tdata & ((VA_W'(1) << ob_w) - VA_W'(1));
  assign oor_w    = (32'(pg_full) >= VIRT_PAGES);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign map_hit    = map_rdata[EW-1];
  assign search_end = (rec_idx >= rc_q);
  assign search_hit = !search_end && rec_match;
  assign search_pos = (32'(rec_idx) >= FRAMES) ? CW'(FRAMES - 1) : rec_idx;

  lpt_map_ram #(
    .DEPTH (VIRT_PAGES),
    .WIDTH (EW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  lpt_recency #(
    .FRAMES (FRAMES),
    .PAGE_W (AW)
  ) u_recency (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (rec_op),
    .load_idx_i (rec_load_idx),
    .key_i      (pg_q),
    .idx_o      (rec_idx),
    .entry_o    (rec_entry),
    .match_o    (rec_match)
  );

  always_comb begin
    state_d      = state_q;
    rc_d         = rc_q;
    fault_cnt_d  = fault_cnt_q;
    map_we       = 1'b0;
    map_addr     = pg_full[AW-1:0];
    map_wdata    = '0;
    rec_op       = '0;
    rec_load_idx = rc_q - CW'(1);
    case (state_q)
      ST_CLEAR: begin
        map_we   = 1'b1;
        map_addr = clr_cnt_q;
        if (32'(clr_cnt_q) == VIRT_PAGES - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = oor_w ? ST_DONE : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (map_hit) begin
          rec_op.idx_clr = 1'b1;
          state_d        = ST_SEARCH;
        end else begin
          if (fault_cnt_q != '1) begin
            fault_cnt_d = fault_cnt_q + FCNT_W'(1);
          end
          if (rc_q < limit_w) begin
            rc_d            = rc_q + CW'(1);
            rec_op.idx_clr  = 1'b1;
            rec_op.carry_ld = 1'b1;
            state_d         = ST_SHIFT;
          end else begin
            rec_op.idx_load = 1'b1;
            state_d         = ST_VSEL;
          end
        end
      end
      ST_SEARCH: begin
        if (search_end || search_hit) begin
          rec_op.idx_clr  = 1'b1;
          rec_op.carry_ld = 1'b1;
          state_d         = ST_SHIFT;
        end else begin
          rec_op.idx_inc = 1'b1;
        end
      end
      ST_VSEL: begin
        map_addr = rec_entry;
        state_d  = ST_VREAD;
      end
      ST_VREAD: begin
        map_we          = 1'b1;
        map_addr        = victim_q;
        rec_op.idx_clr  = 1'b1;
        rec_op.carry_ld = 1'b1;
        state_d         = ST_SHIFT;
      end
      ST_SHIFT: begin
        rec_op.rot_step = 1'b1;
        if (rec_idx == pos_q) begin
          map_we    = fault_q;
          map_addr  = pg_q;
          map_wdata = {1'b1, frame_q};
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign phys_full = (VA_W'(frame_q) << ob_q) | VA_W'(off_q);
  assign frame_ext = 32'(frame_q);
  assign result_w  = oor_q ? {fault_cnt_q, 1'b1, 1'b0, FUSED_W'(0), PHYS_W'(0)}
                           : {fault_cnt_q, 1'b0, fault_q, frame_ext[FUSED_W-1:0],
                              phys_full[PHYS_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ob_cfg_q    <= OFFSET_BITS_RST;
      fr_cfg_q    <= FRAMES_RST;
      rc_q        <= '0;
      fault_cnt_q <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rc_q        <= rc_d;
      fault_cnt_q <= fault_cnt_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_IDX_OFFSET_BITS) begin
          ob_cfg_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_IDX_FRAMES) begin
          fr_cfg_q <= cfg_data_i;
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pg_q  <= pg_full[AW-1:0];
      off_q <= off_full[MAX_OFFSET_BITS-1:0];
      ob_q  <= ob_w;
      oor_q <= oor_w;
    end
    if (state_q == ST_LOOK) begin
      fault_q <= !map_hit;
      pos_q   <= rc_q - CW'(1);
      if (map_hit) begin
        frame_q <= map_rdata[FW-1:0];
      end else if (rc_q < limit_w) begin
        frame_q <= rc_q[FW-1:0];
        pos_q   <= rc_q;
      end
    end
    if (state_q == ST_SEARCH) begin
      pos_q <= search_pos;
    end
    if (state_q == ST_VSEL) begin
      victim_q <= rec_entry;
    end
    if (state_q == ST_VREAD) begin
      frame_q <= map_rdata[FW-1:0];
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= result_w;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rc_q) <= FRAMES)
    else $error("resident count beyond frame count");

  a_fault_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_cnt_q != $past(fault_cnt_q)) |-> (fault_cnt_q == $past(fault_cnt_q) + FCNT_W'(1)))
    else $error("fault count moved by other than one");

  a_rc_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc_q != $past(rc_q)) |-> ($past(state_q) == ST_LOOK && !$past(map_hit)))
    else $error("resident count changed outside a fault");

  a_map_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_we && map_wdata[EW-1]) |-> (state_q == ST_SHIFT && fault_q))
    else $error("page map entry set outside fault completion");

endmodule

// ===== tb/lru_page_translation_tb.sv =====
`timescale 1ns / 1ps

module lru_page_translation_tb;
  import lpt_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned BURST_ITEMS = 20;
  localparam logic [CIDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [FCNT_W-1:0]  fault_total;
    logic               out_of_range;
    logic               page_fault;
    logic [FUSED_W-1:0] frame_used;
    logic [PHYS_W-1:0]  phys_addr;
  } xlat_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [VA_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  lru_page_translation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  logic [VA_W-1:0] addr_q[$];
  xlat_t           xlat_q[$];

  logic [CFG_W-1:0]  offset_bits_reg = OFFSET_BITS_RST;
  logic [CFG_W-1:0]  frames_reg = FRAMES_RST;
  bit                page_valid [VIRT_PAGES_DEF];
  logic [FUSED_W-1:0] page_frame [VIRT_PAGES_DEF];
  logic [7:0]        mru_pages [FRAMES_DEF];
  int unsigned       resident = 0;
  logic [FCNT_W-1:0] fault_cnt = '0;

  int unsigned mismatches = 0;
  int unsigned hit_cnt = 0;
  int unsigned fault_seen = 0;
  int unsigned oor_cnt = 0;
  int unsigned reg_writes = 0;
  bit          no_idle = 1'b0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  logic [5:0]  rx_cnt = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_offset_bits(logic [CFG_W-1:0] v);
    if (v < OFFSET_BITS_MIN) return OFFSET_BITS_MIN;
    if (v > MAX_OFFSET_BITS_DEF) return MAX_OFFSET_BITS_DEF;
    return v;
  endfunction

  function automatic int unsigned eff_frames(logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > FRAMES_DEF) return FRAMES_DEF;
    return v;
  endfunction

  task automatic promote(int unsigned pos, int unsigned pg);
    int unsigned k;
    if (pos >= FRAMES_DEF) pos = FRAMES_DEF - 1;
    for (k = pos; k > 0; k--) mru_pages[k] = mru_pages[k - 1];
    mru_pages[0] = pg[7:0];
  endtask

  task automatic translate_page(input logic [VA_W-1:0] va, output xlat_t res);
    int unsigned ob, lim, offset, pg, pos, last, victim, frm;
    ob = eff_offset_bits(offset_bits_reg);
    lim = eff_frames(frames_reg);
    offset = va & ((1 << ob) - 1);
    pg = va >> ob;
    res = '0;
    if (pg >= VIRT_PAGES_DEF) begin
      res.out_of_range = 1'b1;
      res.fault_total = fault_cnt;
      oor_cnt++;
      return;
    end
    if (page_valid[pg]) begin
      frm = page_frame[pg];
      pos = 0;
      while (pos < resident && pos < FRAMES_DEF && mru_pages[pos] != pg) pos++;
      promote(pos, pg);
      hit_cnt++;
    end else begin
      res.page_fault = 1'b1;
      fault_seen++;
      if (fault_cnt != '1) fault_cnt++;
      if (resident < lim) begin
        frm = resident;
        resident++;
        promote(resident - 1, pg);
      end else begin
        last = resident - 1;
        if (last >= FRAMES_DEF) last = FRAMES_DEF - 1;
        victim = mru_pages[last];
        frm = page_frame[victim];
        page_valid[victim] = 1'b0;
        page_frame[victim] = '0;
        promote(last, pg);
      end
      page_valid[pg] = 1'b1;
      page_frame[pg] = frm[FUSED_W-1:0];
    end
    res.phys_addr = PHYS_W'((frm << ob) + offset);
    res.frame_used = frm[FUSED_W-1:0];
    res.fault_total = fault_cnt;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < 50)
      $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (addr_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= addr_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          if (no_idle || $urandom_range(0, 3) == 0) gap_left <= 0;
          else gap_left <= $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_cnt <= '0;
    end else begin
      rx_cnt <= rx_cnt + 1'b1;
      if (rx_cnt == '0) rx_mode <= rx_mode_e'($urandom_range(0, 2));
      if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
          default:   m_axis_tready <= (rx_cnt[1:0] == 2'd0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    xlat_t got, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        reg_writes++;
        case (cfg_index_i)
          CFG_IDX_OFFSET_BITS: offset_bits_reg = cfg_data_i;
          CFG_IDX_FRAMES:      frames_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (xlat_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, data", got, 0);
        end else begin
          want = xlat_q.pop_front();
          if (got.phys_addr != want.phys_addr)
            report_mismatch("phys_addr", got.phys_addr, want.phys_addr);
          if (got.frame_used != want.frame_used)
            report_mismatch("frame_used", got.frame_used, want.frame_used);
          if (got.page_fault != want.page_fault)
            report_mismatch("page_fault", got.page_fault, want.page_fault);
          if (got.out_of_range != want.out_of_range)
            report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
          if (got.fault_total != want.fault_total)
            report_mismatch("fault_total", got.fault_total, want.fault_total);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        translate_page(s_axis_tdata, want);
        xlat_q.push_back(want);
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timed out with %0d translations outstanding.", xlat_q.size());
    $display("lru_page_translation_tb: FAIL");
    $finish;
  end

  task automatic wait_idle(int unsigned quiet);
    do @(negedge clk_i); while (addr_q.size() != 0 || s_axis_tvalid || xlat_q.size() != 0);
    repeat (quiet) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [VA_W-1:0] pick_addr(int unsigned ob, int unsigned base,
                                                int unsigned span);
    int unsigned roll, pg;
    roll = $urandom_range(0, 99);
    if (roll < 10) return VA_W'($urandom);
    if (roll < 16) begin
      if (ob == MAX_OFFSET_BITS_DEF) pg = VIRT_PAGES_DEF - 1;
      else pg = $urandom_range(VIRT_PAGES_DEF, 32'hFFFF >> ob);
    end else begin
      pg = base + $urandom_range(0, span - 1);
    end
    return VA_W'((pg << ob) | ($urandom & ((1 << ob) - 1)));
  endfunction

  initial begin
    int unsigned phase_off [8];
    int unsigned phase_frm [8];
    int unsigned ob, span, base, pg;
    int unsigned settings;
    phase_off = '{0, 8, 15, 5, 4, 6, 12, 8};
    phase_frm = '{0, 8, 15, 3, 1, 2, 9, 5};
    settings = 3;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill all eight frames, then keep faulting so the oldest pages are evicted in turn.
    addr_q.push_back(16'h0000);
    addr_q.push_back(16'h007F);
    addr_q.push_back(16'h7FFF);
    addr_q.push_back(16'h8000);
    addr_q.push_back(16'hFFFF);
    for (int unsigned p = 1; p < 8; p++) addr_q.push_back(VA_W'((p << 7) | p));
    addr_q.push_back(16'h0400);
    addr_q.push_back(16'h0000);
    addr_q.push_back(16'h0080);
    wait_idle(4);

    // Writes to unused indexes must not disturb anything; zero values clamp.
    write_reg(CFG_IDX_SPARE_LO, 4'd3);
    write_reg(CFG_IDX_SPARE_HI, 4'd15);
    write_reg(CFG_IDX_OFFSET_BITS, 4'd0);
    write_reg(CFG_IDX_FRAMES, 4'd0);
    addr_q.push_back(16'hFFFF);
    addr_q.push_back(16'h0FF0);
    addr_q.push_back(16'h0010);
    addr_q.push_back(16'h0010);
    wait_idle(4);
    write_reg(CFG_IDX_OFFSET_BITS, 4'd15);
    write_reg(CFG_IDX_FRAMES, 4'd15);
    addr_q.push_back(16'h0000);
    addr_q.push_back(16'hFFFF);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle(4);
      if (ph < 8) begin
        write_reg(CFG_IDX_OFFSET_BITS, CFG_W'(phase_off[ph]));
        write_reg(CFG_IDX_FRAMES, CFG_W'(phase_frm[ph]));
      end else begin
        write_reg(CFG_IDX_OFFSET_BITS, CFG_W'($urandom_range(0, 15)));
        write_reg(CFG_IDX_FRAMES, CFG_W'($urandom_range(0, 15)));
      end
      settings++;
      ob = eff_offset_bits(offset_bits_reg);
      span = eff_frames(frames_reg) + $urandom_range(1, 4);
      base = $urandom_range(0, VIRT_PAGES_DEF - span);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_idle(1);
        addr_q.push_back(pick_addr(ob, base, span));
      end
    end

    // Run back to back with the frame setting at one, alternating between two neighbouring pages.
    wait_idle(4);
    write_reg(CFG_IDX_FRAMES, 4'd1);
    write_reg(CFG_IDX_OFFSET_BITS, 4'd8);
    settings++;
    no_idle = 1'b1;
    base = $urandom_range(0, VIRT_PAGES_DEF - 2);
    pg = base;
    for (int unsigned i = 0; i < BURST_ITEMS; i++) begin
      pg = base + (i & 1);
      addr_q.push_back(VA_W'((pg << 8) | $urandom_range(0, 255)));
    end
    addr_q.push_back(VA_W'((pg << 8) | $urandom_range(0, 255)));
    wait_idle(4);
    no_idle = 1'b0;
    write_reg(CFG_IDX_OFFSET_BITS, 4'd4);
    settings++;
    addr_q.push_back(16'hFFFF);
    addr_q.push_back(16'h0ABC);
    addr_q.push_back(16'h0ABC);
    wait_idle(40);

    if (xlat_q.size() != 0) report_mismatch("translations never returned", xlat_q.size(), 0);
    $display("Checked %0d translations: %0d hits, %0d page faults, %0d beyond the table.",
             hit_cnt + fault_seen + oor_cnt, hit_cnt, fault_seen, oor_cnt);
    $display("Used %0d register writes over %0d settings; fault count ended at %0d.",
             reg_writes, settings, fault_cnt);
    if (mismatches == 0) begin
      $display("lru_page_translation_tb: PASS");
    end else begin
      $display("lru_page_translation_tb: FAIL");
    end
    $finish;
  end

endmodule
